// ===== rtl/core/ikc_pkg.sv =====
package ikc_pkg;

    localparam int MaxKernel = 7;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int LineRows  = MaxKernel + 1;
    localparam int TapCount  = MaxKernel * MaxKernel;
    localparam int LineDepth = LineRows * MaxWidth;

    localparam int ColW  = $clog2(MaxWidth);
    localparam int RowW  = $clog2(MaxHeight);
    localparam int SlotW = $clog2(LineRows);
    localparam int AddrW = $clog2(LineDepth);
    localparam int TapW  = $clog2(TapCount);
    localparam int KW    = $clog2(MaxKernel + 1);

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_DRAIN = 2'd1;
    localparam logic [1:0] CMD_COEF  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KSIZE  = 2'd2;
    localparam logic [1:0] REG_SCALE  = 2'd3;

    // Multiply-accumulate command from the sequencer to the datapath.
    typedef struct packed {
        logic clear;
        logic acc;
    } mac_ctrl_t;

endpackage

// ===== rtl/core/ikc_mac.sv =====
module ikc_mac
(
    input  logic              clk,
    input  ikc_pkg::mac_ctrl_t ctrl,
    input  logic signed [15:0] weight,
    input  logic [31:0]        pixel,
    output logic signed [35:0] sum_r,
    output logic signed [35:0] sum_g,
    output logic signed [35:0] sum_b
);

    logic signed [35:0] sum_r_reg, sum_g_reg, sum_b_reg;

    // One tap per cycle: three narrow 16x9 products feed three accumulators.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            sum_r_reg <= sum_r_reg
                + 36'(25'(weight) * 25'($signed({1'b0, pixel[7:0]})));
            sum_g_reg <= sum_g_reg
                + 36'(25'(weight) * 25'($signed({1'b0, pixel[15:8]})));
            sum_b_reg <= sum_b_reg
                + 36'(25'(weight) * 25'($signed({1'b0, pixel[23:16]})));
        end
    end

    assign sum_r = sum_r_reg;
    assign sum_g = sum_g_reg;
    assign sum_b = sum_b_reg;

endmodule

// ===== rtl/core/image_kernel_convolution.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------------------------
// input     | in_valid/in_ready  | cmd, pixel_r/g/b/a, coef_index, coef_value
// output    | out_valid/out_ready| out_r, out_g, out_b, out_a, frame_last
// config    | cfg_we             | cfg_index, cfg_data
//
// A coefficient write or an item with no ready output passes the check state (a
// pixel or drain also the wait state) and returns to idle. An item that releases
// an output pixel walks all k*k taps (k = kernel side): one shared MAC unit
// handles one tap a cycle from the single line-store read port, then one shared
// multiplier scales R, G and B in turn. Reset (rst_n low, asynchronous) clears
// positions and control state; the line store and weights are undefined until
// written. A waiting result sits in the output register; the next item is taken
// while it waits and stalls only before its own result has to be written.
module image_kernel_convolution
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         pixel_r,
    input  logic [7:0]         pixel_g,
    input  logic [7:0]         pixel_b,
    input  logic [7:0]         pixel_a,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_r,
    output logic [7:0]         out_g,
    output logic [7:0]         out_b,
    output logic [7:0]         out_a,
    output logic               frame_last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TAP   = 4'd2;
    localparam logic [3:0] S_LAST  = 4'd3;
    localparam logic [3:0] S_CTR   = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0] state_reg, state_next;

    // Configuration.
    logic [10:0] width_cfg_reg;
    logic [12:0] height_cfg_reg;
    logic [2:0]  ksize_cfg_reg;
    logic signed [23:0] scale_reg;

    // Positions.
    logic [ikc_pkg::ColW-1:0] in_col_reg, out_col_reg;
    logic [ikc_pkg::RowW-1:0] in_row_reg, out_row_reg;
    logic in_done_reg;

    // Clamped geometry, registered to keep the compares short.
    logic [ikc_pkg::ColW:0] w_reg;
    logic [ikc_pkg::RowW:0] h_reg;
    logic [ikc_pkg::KW-1:0] k_reg;
    logic [ikc_pkg::KW-1:0] before_reg;
    logic [ikc_pkg::KW-1:0] after_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 11'd640;
            height_cfg_reg <= 13'd480;
            ksize_cfg_reg  <= 3'd3;
            scale_reg      <= 24'sd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ikc_pkg::REG_WIDTH:  width_cfg_reg  <= cfg_data[10:0];
                ikc_pkg::REG_HEIGHT: height_cfg_reg <= cfg_data[12:0];
                ikc_pkg::REG_KSIZE:  ksize_cfg_reg  <= cfg_data[2:0];
                ikc_pkg::REG_SCALE:  scale_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    logic [ikc_pkg::KW-1:0] k_c;
    always_comb
    begin
        k_c = (ksize_cfg_reg == 3'd0) ? ikc_pkg::KW'(1)
            : (32'(ksize_cfg_reg) > ikc_pkg::MaxKernel) ? ikc_pkg::KW'(ikc_pkg::MaxKernel)
            : ikc_pkg::KW'(ksize_cfg_reg);
    end

    always_ff @(posedge clk)
    begin
        w_reg <= (width_cfg_reg == 11'd0) ? (ikc_pkg::ColW+1)'(1)
               : (32'(width_cfg_reg) > ikc_pkg::MaxWidth) ? (ikc_pkg::ColW+1)'(ikc_pkg::MaxWidth)
               : (ikc_pkg::ColW+1)'(width_cfg_reg);
        h_reg <= (height_cfg_reg == 13'd0) ? (ikc_pkg::RowW+1)'(1)
               : (32'(height_cfg_reg) > ikc_pkg::MaxHeight) ? (ikc_pkg::RowW+1)'(ikc_pkg::MaxHeight)
               : (ikc_pkg::RowW+1)'(height_cfg_reg);
        k_reg      <= k_c;
        before_reg <= k_c >> 1;
        after_reg  <= k_c - ikc_pkg::KW'(1) - (k_c >> 1);
    end

    // Held item.
    logic [1:0]  cmd_reg;
    logic [31:0] px_reg;
    logic [5:0]  cidx_reg;
    logic signed [15:0] cval_reg;

    // Memories.
    logic [31:0] line_mem [ikc_pkg::LineDepth];
    logic signed [15:0] weight_mem [ikc_pkg::TapCount];
    logic [31:0] line_rd_reg;
    logic signed [15:0] weight_rd_reg;

    // Tap walk.
    logic [ikc_pkg::KW-1:0] kx_reg, ky_reg;
    logic [ikc_pkg::TapW-1:0] tap_reg;
    logic [ikc_pkg::ColW-1:0] rx_reg;
    logic [ikc_pkg::RowW-1:0] ry_reg;
    logic [1:0] chan_reg;
    logic acc_d_reg;

    // Output register.
    logic out_valid_reg;
    logic [7:0] r_reg, g_reg, b_reg, a_reg;
    logic last_reg;

    logic in_xfer, out_xfer;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Clamped tap coordinates.
    logic signed [ikc_pkg::ColW+1:0] tx_s;
    logic signed [ikc_pkg::RowW+1:0] ty_s;
    logic [ikc_pkg::ColW-1:0] tx;
    logic [ikc_pkg::RowW-1:0] ty;
    always_comb
    begin
        tx_s = $signed({2'b0, out_col_reg}) + $signed((ikc_pkg::ColW+2)'(kx_reg))
             - $signed((ikc_pkg::ColW+2)'(before_reg));
        ty_s = $signed({2'b0, out_row_reg}) + $signed((ikc_pkg::RowW+2)'(ky_reg))
             - $signed((ikc_pkg::RowW+2)'(before_reg));
        if (tx_s < 0)
            tx = '0;
        else if (tx_s >= $signed({1'b0, w_reg}))
            tx = ikc_pkg::ColW'(w_reg - 1'b1);
        else
            tx = ikc_pkg::ColW'(tx_s);
        if (ty_s < 0)
            ty = '0;
        else if (ty_s >= $signed({1'b0, h_reg}))
            ty = ikc_pkg::RowW'(h_reg - 1'b1);
        else
            ty = ikc_pkg::RowW'(ty_s);
    end

    logic [ikc_pkg::ColW:0] rx_c;
    logic [ikc_pkg::RowW:0] ry_c;
    always_comb
    begin
        rx_c = (ikc_pkg::ColW+1)'(out_col_reg) + (ikc_pkg::ColW+1)'(after_reg);
        ry_c = (ikc_pkg::RowW+1)'(out_row_reg) + (ikc_pkg::RowW+1)'(after_reg);
        if (rx_c >= w_reg) rx_c = w_reg - 1'b1;
        if (ry_c >= h_reg) ry_c = h_reg - 1'b1;
    end

    logic ready_out;
    assign ready_out = in_done_reg || (in_row_reg > ry_reg)
                     || ((in_row_reg == ry_reg) && (in_col_reg > rx_reg));

    logic write_px;
    assign write_px = (state_reg == S_CHECK) && (cmd_reg == ikc_pkg::CMD_PIXEL) && !in_done_reg;

    logic [ikc_pkg::AddrW-1:0] wr_addr, rd_addr;
    assign wr_addr = {in_row_reg[ikc_pkg::SlotW-1:0], in_col_reg};

    always_comb
    begin
        if (state_reg == S_LAST)
            rd_addr = {out_row_reg[ikc_pkg::SlotW-1:0], out_col_reg};
        else
            rd_addr = {ty[ikc_pkg::SlotW-1:0], tx};
    end

    always_ff @(posedge clk)
    begin
        if (write_px)
            line_mem[wr_addr] <= px_reg;
        line_rd_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK && cmd_reg == ikc_pkg::CMD_COEF
            && 32'(cidx_reg) < ikc_pkg::TapCount)
            weight_mem[cidx_reg[ikc_pkg::TapW-1:0]] <= cval_reg;
        weight_rd_reg <= weight_mem[tap_reg];
    end

    ikc_pkg::mac_ctrl_t mac_ctrl;
    logic signed [35:0] sum_r, sum_g, sum_b;
    assign mac_ctrl.clear = (state_reg == S_CHECK);
    assign mac_ctrl.acc   = acc_d_reg;

    ikc_mac u_mac
    (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .weight (weight_rd_reg),
        .pixel  (line_rd_reg),
        .sum_r  (sum_r),
        .sum_g  (sum_g),
        .sum_b  (sum_b)
    );

    // Shared scaling multiplier: 36 x 24 cut into two partial products.
    logic signed [35:0] sel_sum;
    logic signed [60:0] prod_lo_reg;
    logic signed [60:0] prod_hi_reg;
    logic [1:0] scale_ch_reg;
    logic scale_v_reg;
    logic [7:0] clamped;
    logic signed [61:0] prod_full;

    always_comb
    begin
        case (chan_reg)
            2'd0:    sel_sum = sum_r;
            2'd1:    sel_sum = sum_g;
            default: sel_sum = sum_b;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= 61'(43'($signed({1'b0, sel_sum[17:0]})) * 43'(scale_reg));
        prod_hi_reg <= 61'(42'($signed(sel_sum[35:18])) * 42'(scale_reg));
        scale_ch_reg <= chan_reg;
        scale_v_reg  <= (state_reg == S_SCALE);
    end

    always_comb
    begin
        prod_full = (62'(prod_hi_reg) <<< 18) + 62'(prod_lo_reg);
        if (prod_full < 0)
            clamped = 8'd0;
        else if ((prod_full >>> 16) > 62'sd255)
            clamped = 8'd255;
        else
            clamped = prod_full[23:16];
    end

    logic last_c;
    assign last_c = ((ikc_pkg::ColW+1)'(out_col_reg) == w_reg - 1'b1)
                 && ((ikc_pkg::RowW+1)'(out_row_reg) == h_reg - 1'b1);

    logic cfg_geom;
    assign cfg_geom = cfg_we && (cfg_index == ikc_pkg::REG_WIDTH
        || cfg_index == ikc_pkg::REG_HEIGHT || cfg_index == ikc_pkg::REG_KSIZE);

    logic tap_end;
    assign tap_end = (kx_reg == k_reg - 1'b1) && (ky_reg == k_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_CHECK;
            S_CHECK:
                if (cmd_reg == ikc_pkg::CMD_COEF || cmd_reg == ikc_pkg::CMD_NOP)
                    state_next = S_IDLE;
                else
                    state_next = S_WAIT;
            S_WAIT:  state_next = ready_out ? S_TAP : S_IDLE;
            S_TAP:   if (tap_end) state_next = S_LAST;
            S_LAST:  state_next = S_CTR;
            S_CTR:   state_next = S_SCALE;
            S_SCALE: if (chan_reg == 2'd2) state_next = S_OUT;
            S_OUT:   if (!scale_v_reg && !out_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            in_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_d_reg     <= 1'b0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            tap_reg       <= '0;
            chan_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_d_reg <= (state_reg == S_TAP);
            if (out_xfer)
                out_valid_reg <= 1'b0;

            if (cfg_geom)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                in_done_reg <= 1'b0;
            end

            if (write_px)
            begin
                if ((ikc_pkg::ColW+1)'(in_col_reg) + 1'b1 >= w_reg)
                begin
                    in_col_reg <= '0;
                    if ((ikc_pkg::RowW+1)'(in_row_reg) + 1'b1 >= h_reg)
                    begin
                        in_row_reg  <= '0;
                        in_done_reg <= 1'b1;
                    end
                    else
                        in_row_reg <= in_row_reg + 1'b1;
                end
                else
                    in_col_reg <= in_col_reg + 1'b1;
            end

            if (state_reg == S_CHECK)
            begin
                kx_reg  <= '0;
                ky_reg  <= '0;
                tap_reg <= '0;
                chan_reg <= '0;
            end

            if (state_reg == S_TAP && !tap_end)
            begin
                tap_reg <= tap_reg + 1'b1;
                if (kx_reg == k_reg - 1'b1)
                begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + 1'b1;
                end
                else
                    kx_reg <= kx_reg + 1'b1;
            end

            if (state_reg == S_SCALE)
                chan_reg <= chan_reg + 1'b1;

            // Hold the finished pixel until the previous one has gone.
            if (state_reg == S_OUT && !scale_v_reg && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                if (last_c)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    in_done_reg <= 1'b0;
                end
                else if ((ikc_pkg::ColW+1)'(out_col_reg) + 1'b1 >= w_reg)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end
                else
                    out_col_reg <= out_col_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    logic [7:0] sr_reg, sg_reg, sb_reg, ctr_a_reg;
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= cmd;
            px_reg   <= {pixel_a, pixel_b, pixel_g, pixel_r};
            cidx_reg <= coef_index;
            cval_reg <= coef_value;
        end
        if (state_reg == S_CHECK)
        begin
            rx_reg <= ikc_pkg::ColW'(rx_c);
            ry_reg <= ikc_pkg::RowW'(ry_c);
        end
        if (state_reg == S_CTR)
            ctr_a_reg <= line_rd_reg[31:24];
        if (scale_v_reg)
        begin
            case (scale_ch_reg)
                2'd0:    sr_reg <= clamped;
                2'd1:    sg_reg <= clamped;
                default: sb_reg <= clamped;
            endcase
        end
        if (state_reg == S_OUT && !scale_v_reg && !out_valid_reg)
        begin
            r_reg    <= sr_reg;
            g_reg    <= sg_reg;
            b_reg    <= sb_reg;
            a_reg    <= ctr_a_reg;
            last_reg <= last_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_r      = r_reg;
    assign out_g      = g_reg;
    assign out_b      = b_reg;
    assign out_a      = a_reg;
    assign frame_last = last_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP) |-> (kx_reg < k_reg) && (ky_reg < k_reg))
        else $error("tap walk out of kernel");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_r))
        else $error("waiting result lost");

endmodule
